// ===== hdl/ptp_pkg.sv =====
// Shared types, constants and register indexes for the point projection block.
package ptp_pkg;

    localparam int MAX_PIXELS_DEF = 524288;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 64;
    localparam int DIM_W   = 11;
    localparam int IDX_W   = 19;
    localparam int IW      = 2 * DIM_W + 1;
    localparam int QW      = DIM_W;
    localparam int REG_W   = 3;

    localparam logic [REG_W-1:0] REG_ROW0_A = 3'd0;
    localparam logic [REG_W-1:0] REG_ROW0_B = 3'd1;
    localparam logic [REG_W-1:0] REG_ROW1_A = 3'd2;
    localparam logic [REG_W-1:0] REG_ROW1_B = 3'd3;
    localparam logic [REG_W-1:0] REG_ROW2_A = 3'd4;
    localparam logic [REG_W-1:0] REG_ROW2_B = 3'd5;
    localparam logic [REG_W-1:0] REG_WIDTH  = 3'd6;
    localparam logic [REG_W-1:0] REG_HEIGHT = 3'd7;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

    // Sideband that travels with every beat down the pipeline
    typedef struct packed {
        logic             valid;
        logic             wr;
        logic [IDX_W-1:0] addr;
        logic             data;
    } side_t;

endpackage

// ===== hdl/point_to_pixel_projection.sv =====
// A projection beat passes dot, divider, bounds, index, mask and output registers.
// Throughput: one beat per cycle; the whole pipeline holds while the output is stalled.
// Mask write beats flow through the same pipeline and give no result.
// Reset: asynchronous, active low; config and valid registers go to defaults, then a
// clearing pass sets all MAX_PIXELS mask bits (524288 by default) with in_stall high.
module point_to_pixel_projection
    import ptp_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [REG_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic signed [COORD_W-1:0] point_w,
    input  logic [IDX_W-1:0]          mask_addr,
    input  logic                      mask_bit,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic [IDX_W-1:0]          pixel_index
);

    localparam int SUM_W = 66 - FRAC_BITS;

    logic [CFG_W-1:0] coef_reg [6];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    logic                      adv;
    logic                      busy;
    side_t                     side_in;
    side_t                     side_d;
    side_t                     side_q;
    side_t                     side_c_reg;
    side_t                     side_i_reg;
    logic signed [COORD_W-1:0] pnt [4];
    logic signed [COORD_W-1:0] coef [3][4];
    logic signed [SUM_W-1:0]   dsum [3];
    logic                      miss_q;
    logic [QW-1:0]             u_q;
    logic [QW-1:0]             v_q;
    logic                      miss_c_reg;
    logic [DIM_W-1:0]          row_c_reg;
    logic [QW-1:0]             u_c_reg;
    logic                      miss_i_reg;
    logic [IW-1:0]             idx_i_reg;
    logic                      res_valid;
    logic                      res_hit;
    logic [IDX_W-1:0]          res_index;
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [IDX_W-1:0]          pixel_index_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                coef_reg[i] <= '0;
            end
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW0_A: coef_reg[0] <= cfg_data;
                REG_ROW0_B: coef_reg[1] <= cfg_data;
                REG_ROW1_A: coef_reg[2] <= cfg_data;
                REG_ROW1_B: coef_reg[3] <= cfg_data;
                REG_ROW2_A: coef_reg[4] <= cfg_data;
                REG_ROW2_B: coef_reg[5] <= cfg_data;
                REG_WIDTH:  width_reg   <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg  <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // Coefficient words unpacked from the register pairs
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                coef[r][c] = coef_reg[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
            end
        end
    end

    // Global advance: everything moves unless the output beat is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = busy || !adv;

    assign side_in.valid = in_valid && !in_stall;
    assign side_in.wr    = req_type;
    assign side_in.addr  = mask_addr;
    assign side_in.data  = mask_bit;
    assign pnt[0] = point_x;
    assign pnt[1] = point_y;
    assign pnt[2] = point_z;
    assign pnt[3] = point_w;

    ptp_dot #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .side_in  (side_in),
        .pnt      (pnt),
        .coef     (coef),
        .side_out (side_d),
        .dsum     (dsum)
    );

    ptp_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .side_in  (side_d),
        .dsum     (dsum),
        .side_out (side_q),
        .miss     (miss_q),
        .u        (u_q),
        .v        (v_q)
    );

    // Bounds check and row flip, then linear index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_c_reg <= '0;
            side_i_reg <= '0;
        end
        else if (adv)
        begin
            side_c_reg <= side_q;
            side_i_reg <= side_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            miss_c_reg <= miss_q || (u_q >= width_reg) || (v_q >= height_reg);
            row_c_reg  <= height_reg - DIM_W'(1) - v_q;
            u_c_reg    <= u_q;
            miss_i_reg <= miss_c_reg;
            idx_i_reg  <= IW'(row_c_reg) * IW'(width_reg) + IW'(u_c_reg);
        end
    end

    ptp_mask #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_mask (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .side_in   (side_i_reg),
        .miss_in   (miss_i_reg),
        .idx_in    (idx_i_reg),
        .busy      (busy),
        .res_valid (res_valid),
        .res_hit   (res_hit),
        .res_index (res_index)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg         <= res_hit;
            pixel_index_reg <= res_hit ? res_index : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign pixel_index = pixel_index_reg;

endmodule

// ===== hdl/ptp_dot.sv =====
// Matrix times point: product stage then shift-and-sum stage.
module ptp_dot
    import ptp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_W     = 66 - FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  side_t                     side_in,
    input  logic signed [COORD_W-1:0] pnt [4],
    input  logic signed [COORD_W-1:0] coef [3][4],
    output side_t                     side_out,
    output logic signed [SUM_W-1:0]   dsum [3]
);

    side_t                   side1_reg;
    side_t                   side2_reg;
    logic signed [63:0]      prod_reg [3][4];
    logic signed [63:0]      prod_next [3][4];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_next [3];

    // Full-precision products
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_next[r][c] = 64'(coef[r][c]) * 64'(pnt[c]);
            end
        end
    end

    // Floor each product to the fraction width and sum a row
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = '0;
            for (int c = 0; c < 4; c++)
            begin
                sum_next[r] = sum_next[r] + SUM_W'(prod_reg[r][c] >>> FRAC_BITS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
        end
        else if (adv)
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign side_out = side2_reg;
    assign dsum     = sum_reg;

endmodule

// ===== hdl/ptp_div.sv =====
// Rounded division of du and dv by dw, one quotient bit per stage.
module ptp_div
    import ptp_pkg::*;
#(
    parameter int SUM_W = 50
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  side_t                   side_in,
    input  logic signed [SUM_W-1:0] dsum [3],
    output side_t                   side_out,
    output logic                    miss,
    output logic [QW-1:0]           u,
    output logic [QW-1:0]           v
);

    localparam int NW = SUM_W + QW + 2;

    // prep stage
    side_t               side_p_reg;
    logic                miss_p_reg;
    logic [NW-1:0]       nu_p_reg;
    logic [NW-1:0]       nv_p_reg;
    logic [NW-1:0]       d_p_reg;
    logic signed [SUM_W+1:0] nu;
    logic signed [SUM_W+1:0] nv;

    // divider chain, index 0 is after the range check
    side_t               side_reg [QW+1];
    logic                miss_reg [QW+1];
    logic [NW-1:0]       ru_reg   [QW+1];
    logic [NW-1:0]       rv_reg   [QW+1];
    logic [NW-1:0]       d_reg    [QW+1];
    logic [QW-1:0]       qu_reg   [QW+1];
    logic [QW-1:0]       qv_reg   [QW+1];

    function automatic logic [NW:0] div_step(input logic [NW-1:0] r, input logic [NW-1:0] dk);
        logic ge;
        ge = (r >= dk);
        return {ge, ge ? r - dk : r};
    endfunction

    // 2*du + dw and 2*dv + dw over the divisor 2*dw
    assign nu = ((SUM_W+2)'(dsum[0]) <<< 1) + (SUM_W+2)'(dsum[2]);
    assign nv = ((SUM_W+2)'(dsum[1]) <<< 1) + (SUM_W+2)'(dsum[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_p_reg  <= '0;
            side_reg[0] <= '0;
        end
        else if (adv)
        begin
            side_p_reg  <= side_in;
            side_reg[0] <= side_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            miss_p_reg <= dsum[2][SUM_W-1] || (dsum[2] == '0) || nu[SUM_W+1] || nv[SUM_W+1];
            nu_p_reg   <= NW'(nu);
            nv_p_reg   <= NW'(nv);
            d_p_reg    <= NW'(dsum[2]) << 1;
            // a quotient of 2^QW or more lies outside any image
            miss_reg[0] <= miss_p_reg || (nu_p_reg >= (d_p_reg << QW))
                                      || (nv_p_reg >= (d_p_reg << QW));
            ru_reg[0]   <= nu_p_reg;
            rv_reg[0]   <= nv_p_reg;
            d_reg[0]    <= d_p_reg;
            qu_reg[0]   <= '0;
            qv_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int K = QW - 1 - j;
        logic [NW:0] su;
        logic [NW:0] sv;

        assign su = div_step(ru_reg[j], d_reg[j] << K);
        assign sv = div_step(rv_reg[j], d_reg[j] << K);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[j+1] <= '0;
            end
            else if (adv)
            begin
                side_reg[j+1] <= side_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                miss_reg[j+1]  <= miss_reg[j];
                d_reg[j+1]     <= d_reg[j];
                ru_reg[j+1]    <= su[NW-1:0];
                rv_reg[j+1]    <= sv[NW-1:0];
                qu_reg[j+1]    <= qu_reg[j] | (su[NW] ? (QW'(1) << K) : '0);
                qv_reg[j+1]    <= qv_reg[j] | (sv[NW] ? (QW'(1) << K) : '0);
            end
        end
    end

    assign side_out = side_reg[QW];
    assign miss     = miss_reg[QW];
    assign u        = qu_reg[QW];
    assign v        = qv_reg[QW];

endmodule

// ===== hdl/ptp_mask.sv =====
// Pixel mask store: clearing pass, bit writes and registered lookup.
module ptp_mask
    import ptp_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  side_t            side_in,
    input  logic             miss_in,
    input  logic [IW-1:0]    idx_in,
    output logic             busy,
    output logic             res_valid,
    output logic             res_hit,
    output logic [IDX_W-1:0] res_index
);

    localparam int AW = $clog2(MAX_PIXELS);

    logic          mem [MAX_PIXELS];
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          valid_b_reg;
    logic          pre_b_reg;
    logic [IDX_W-1:0] idx_b_reg;
    logic          rd_reg;
    logic          wr_ok;
    logic          rd_ok;

    assign wr_ok = side_in.valid && side_in.wr
                   && (IW'(side_in.addr) < IW'(MAX_PIXELS));
    assign rd_ok = side_in.valid && !side_in.wr && !miss_in
                   && (idx_in < IW'(MAX_PIXELS));

    // Clearing pass after reset sets every bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(MAX_PIXELS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= 1'b1;
        end
        else if (adv && wr_ok)
        begin
            mem[AW'(side_in.addr)] <= side_in.data;
        end
        if (adv && rd_ok)
        begin
            rd_reg <= mem[AW'(idx_in)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_b_reg <= side_in.valid && !side_in.wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_b_reg <= rd_ok;
            idx_b_reg <= idx_in[IDX_W-1:0];
        end
    end

    assign busy      = clearing_reg;
    assign res_valid = valid_b_reg;
    assign res_hit   = pre_b_reg && rd_reg;
    assign res_index = idx_b_reg;

endmodule

// ===== hdl/ptp_checker.sv =====
// Port-level checks for the point projection block and their binding.
module ptp_checker
    import ptp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             hit,
    input logic [IDX_W-1:0] pixel_index
);

    // A held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(pixel_index))
        else $error("output beat changed while stalled");

    // A miss reports index zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> pixel_index == '0)
        else $error("miss with non-zero index");

    // Input is held while the output is blocked
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input open while output blocked");

    // Mask clearing pass holds the input off straight after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("input open during mask clearing");

endmodule

bind point_to_pixel_projection ptp_checker u_ptp_checker (.*);
